// ===== rtl/rtc_pkg.sv =====
// Package for the region table allocator core.
// Holds the operation and status codes and the stream word widths.
// No dependencies.
package rtc_pkg;

  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 80;

  typedef enum logic [2:0] {
    OP_ADD_MEM    = 3'd0,
    OP_REMOVE_MEM = 3'd1,
    OP_RESERVE    = 3'd2,
    OP_FREE       = 3'd3,
    OP_ALLOC      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_FIT = 2'd2
  } status_t;

endpackage

// ===== rtl/region_table_add_remove_alloc_core.sv =====
// Region table allocator: memory and reserved tables held in one RAM, two banks per table.
// Each operation walks its table entry by entry (one RAM read port, one write port);
// allocate walks the memory table and then the reserved table.
// One word is processed at a time; a finished result waits in the output register.
// Reset (synchronous, active high) empties both tables at once; RAM contents are not cleared.
module region_table_add_remove_alloc_core #(
  parameter int MAX_REGIONS = 128,
  parameter int ADDR_BITS   = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // operation[2:0], base[34:3], size[66:35], align[98:67], zero fill above
  input  logic [rtc_pkg::S_DATA_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status[1:0], address[33:2], region_count[41:34], total_bytes[73:42], zero fill above
  output logic [rtc_pkg::M_DATA_W-1:0] m_tdata
);
  import rtc_pkg::*;

  localparam int A  = ADDR_BITS;
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 2);
  localparam int EW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
  localparam int MA = IW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EVAL, S_EVAL2, S_LAST, S_SRCH_READ, S_SRCH_EVAL, S_COMMIT, S_OUT
  } state_t;

  state_t        state;
  logic [2:0]    op_q;
  logic          tbl;
  logic          is_add;
  logic [1:0]    bank;
  logic [CW-1:0] cnt_mem, cnt_res;
  logic [31:0]   tot_mem, tot_res;
  logic [A-1:0]  nbase, nend;
  logic [31:0]   size_q, mask_q;
  logic          placed;
  logic [CW-1:0] i, n;
  logic [31:0]   tot;
  status_t       status_q;
  logic [A-1:0]  addr_q;

  // Input fields.
  logic [2:0]  in_op;
  logic [31:0] in_base, in_size, in_align;
  assign in_op    = s_tdata[2:0];
  assign in_base  = s_tdata[34:3];
  assign in_size  = s_tdata[66:35];
  assign in_align = s_tdata[98:67];

  // Size capped at the top of the address space.
  logic [EW-1:0] top_e, base_e, size_e, csz;
  assign top_e  = {{(EW-A){1'b0}}, {A{1'b1}}};
  assign base_e = EW'(in_base);
  assign size_e = EW'(in_size);
  always_comb begin
    if (base_e > top_e) begin
      csz = '0;
    end else if (size_e > top_e - base_e) begin
      csz = top_e - base_e;
    end else begin
      csz = size_e;
    end
  end

  // RAM: address is {table, bank, index}, word is {size, base}.
  logic          we;
  logic [MA-1:0] waddr, raddr;
  logic [2*A-1:0] rdata;
  logic          rtbl;
  logic [A-1:0]  rb, rs, re;
  logic          push_en;
  logic [A-1:0]  push_b, push_s;
  logic [CW-1:0] cur_cnt;

  assign rb = rdata[A-1:0];
  assign rs = rdata[2*A-1:A];
  assign re = rb + rs;
  assign rtbl = (state == S_SRCH_READ || state == S_SRCH_EVAL) ? 1'b0 : tbl;
  assign raddr = {rtbl, bank[rtbl], i[IW-1:0]};
  assign waddr = {tbl, ~bank[tbl], n[IW-1:0]};
  assign we = push_en && (n < CW'(MAX_REGIONS));
  assign cur_cnt = tbl ? cnt_res : cnt_mem;

  rtc_ram #(.DW(2*A), .AW(MA)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({push_s, push_b}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Words pushed into the new bank for the current entry.
  always_comb begin
    push_en = 1'b0;
    push_b  = rb;
    push_s  = rs;
    case (state)
      S_EVAL: begin
        if (is_add) begin
          if (re < nbase) begin
            push_en = 1'b1;
          end else if (rb > nend) begin
            push_en = 1'b1;
            if (!placed) begin
              push_b = nbase;
              push_s = nend - nbase;
            end
          end
        end else if (re <= nbase || rb >= nend) begin
          push_en = 1'b1;
        end else if (rb < nbase) begin
          push_en = 1'b1;
          push_s  = nbase - rb;
        end else if (re > nend) begin
          push_en = 1'b1;
          push_b  = nend;
          push_s  = re - nend;
        end
      end
      S_EVAL2: begin
        push_en = 1'b1;
        if (!is_add) begin
          push_b = nend;
          push_s = re - nend;
        end
      end
      S_LAST: begin
        push_en = !placed;
        push_b  = nbase;
        push_s  = nend - nbase;
      end
      default: ;
    endcase
  end

  // Allocation search arithmetic.
  logic [EW-1:0] cand;
  logic [EW-1:0] cand_end;
  logic          fits;
  assign fits     = EW'(rs) >= EW'(size_q);
  assign cand     = (EW'(re) - EW'(size_q)) & ~EW'(mask_q);
  assign cand_end = cand + EW'(size_q);

  logic last_entry;
  assign last_entry = (i + CW'(1)) == cur_cnt;

  logic [CW-1:0] r_cnt;
  logic [31:0]   r_tot;
  assign r_cnt = tbl ? cnt_res : cnt_mem;
  assign r_tot = tbl ? tot_res : tot_mem;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bank     <= '0;
      cnt_mem  <= '0;
      cnt_res  <= '0;
      tot_mem  <= '0;
      tot_res  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (push_en) begin
        n   <= n + CW'(1);
        tot <= tot + 32'(push_s);
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q     <= in_op;
            addr_q   <= '0;
            i        <= '0;
            n        <= '0;
            tot      <= '0;
            placed   <= 1'b0;
            nbase    <= A'(in_base);
            nend     <= A'(base_e + csz);
            size_q   <= in_size;
            mask_q   <= (in_align == 32'd0) ? 32'd0 : in_align - 32'd1;
            status_q <= ST_OK;
            case (in_op)
              OP_ADD_MEM, OP_REMOVE_MEM, OP_RESERVE, OP_FREE: begin
                tbl    <= (in_op == OP_RESERVE || in_op == OP_FREE);
                is_add <= (in_op == OP_ADD_MEM || in_op == OP_RESERVE);
                if (csz == '0) begin
                  state <= S_OUT;
                end else if (((in_op == OP_RESERVE || in_op == OP_FREE) ? cnt_res : cnt_mem)
                             == '0) begin
                  state <= (in_op == OP_ADD_MEM || in_op == OP_RESERVE) ? S_LAST : S_COMMIT;
                end else begin
                  state <= S_READ;
                end
              end
              OP_ALLOC: begin
                tbl      <= 1'b1;
                is_add   <= 1'b1;
                status_q <= ST_NO_FIT;
                if (in_size == 32'd0 || cnt_mem == '0) begin
                  state <= S_OUT;
                end else begin
                  i     <= cnt_mem - CW'(1);
                  state <= S_SRCH_READ;
                end
              end
              default: begin
                tbl   <= 1'b0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (is_add && !(re < nbase) && rb > nend && !placed) begin
            placed <= 1'b1;
            state  <= S_EVAL2;
          end else if (!is_add && !(re <= nbase || rb >= nend) && rb < nbase && re > nend) begin
            state <= S_EVAL2;
          end else begin
            if (is_add && !(re < nbase) && !(rb > nend)) begin
              if (rb < nbase) nbase <= rb;
              if (re > nend) nend <= re;
            end
            if (last_entry) begin
              state <= is_add ? S_LAST : S_COMMIT;
            end else begin
              i     <= i + CW'(1);
              state <= S_READ;
            end
          end
        end
        S_EVAL2: begin
          if (last_entry) begin
            state <= is_add ? S_LAST : S_COMMIT;
          end else begin
            i     <= i + CW'(1);
            state <= S_READ;
          end
        end
        S_LAST: state <= S_COMMIT;
        S_SRCH_READ: state <= S_SRCH_EVAL;
        S_SRCH_EVAL: begin
          if (fits && cand >= EW'(rb)) begin
            if (cand == '0) begin
              state <= S_OUT;
            end else begin
              // The found address is kept apart, as merging may lower nbase.
              addr_q <= A'(cand);
              nbase  <= A'(cand);
              nend   <= A'(cand_end);
              i      <= '0;
              state  <= (cnt_res == '0) ? S_LAST : S_READ;
            end
          end else if (i == '0) begin
            state <= S_OUT;
          end else begin
            i     <= i - CW'(1);
            state <= S_SRCH_READ;
          end
        end
        S_COMMIT: begin
          if (n > CW'(MAX_REGIONS)) begin
            status_q <= ST_FULL;
            if (op_q == OP_ALLOC) begin
              addr_q <= '0;
            end
          end else begin
            status_q  <= ST_OK;
            bank[tbl] <= ~bank[tbl];
            if (tbl) begin
              cnt_res <= n;
              tot_res <= tot;
            end else begin
              cnt_mem <= n;
              tot_mem <= tot;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, r_tot, 8'(r_cnt), 32'(addr_q), status_q};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_mem <= CW'(MAX_REGIONS) && cnt_res <= CW'(MAX_REGIONS))
    else $error("region count above table depth");
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");
  a_addr_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[33:2] == 32'd0)
    else $error("address reported on failure");
`endif

endmodule

// ===== rtl/rtc_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
// One write port and one read port.
// No dependencies.
module rtc_ram #(
  parameter int DW = 64,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
